// ===== rtl/csvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types, constants and character helpers of the CSV field splitter.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  // default size of the trailing whitespace hold buffer
  localparam int DEF_MAX_PENDING = 16;

  // quote run counter and its saturation bound
  localparam int QRUN_W        = 4;
  localparam int QUOTE_RUN_MAX = 15;

  // most results one item may deliver
  localparam int OUT_LIMIT = 32;

  // entries of the queue between front and back end
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_DELIM = 1'b0,
    REG_QUOTE_SEL   = 1'b1
  } cfg_reg_t;

  // field delimiter and text delimiter codes
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  // classified item passed from front to back end
  typedef struct packed {
    logic       eol;
    logic       is_quote;
    logic       is_delim;
    logic       is_ws;
    logic [7:0] ch;
  } csvfs_item_t;

  function automatic logic [7:0] delim_char(input logic [1:0] sel);
    logic [7:0] c;
    case (sel)
      2'd0:    c = CH_COMMA;
      2'd1:    c = CH_SEMI;
      2'd2:    c = CH_COLON;
      default: c = CH_TAB;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] quote_char(input logic sel);
    return sel ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  // whitespace: control codes 9..13, space, next line and no-break space
  function automatic logic is_space(input logic [7:0] c);
    return c inside {[8'd9:8'd13], 8'd32, 8'h85, 8'hA0};
  endfunction

endpackage

// ===== rtl/csvfs_in_if.sv =====
// ----------------------------------------------------------------------------
// csvfs_in_if
// Input item channel: one line byte or an end-of-line marker.
// ----------------------------------------------------------------------------
interface csvfs_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, op, ch, input ready);
  modport sink   (input valid, op, ch, output ready);
endinterface

// ===== rtl/csvfs_out_if.sv =====
// ----------------------------------------------------------------------------
// csvfs_out_if
// Result item channel: one field character or a field end marker.
// ----------------------------------------------------------------------------
interface csvfs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       field_end;
  logic       line_end;
  logic       field_dropped;
  logic       space_overflow;
  logic       last;

  modport source (output valid, out_char, char_valid, field_end, line_end,
                  field_dropped, space_overflow, last, input ready);
  modport sink   (input valid, out_char, char_valid, field_end, line_end,
                  field_dropped, space_overflow, last, output ready);
endinterface

// ===== rtl/csvfs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// csvfs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface csvfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/csvfs_queue.sv =====
// ----------------------------------------------------------------------------
// csvfs_queue
// Short first-in first-out queue of classified items between the front
// and back end.
// ----------------------------------------------------------------------------
module csvfs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  csvfs_pkg::csvfs_item_t push_item,
  output logic                   full,
  input  logic                   pop,
  output csvfs_pkg::csvfs_item_t head,
  output logic                   nonempty
);
  import csvfs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  csvfs_item_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_item;
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/csvfs_front.sv =====
// ----------------------------------------------------------------------------
// csvfs_front
// Accepts input items, classifies each byte against the configured
// delimiters and whitespace, and queues it for the back end.
// ----------------------------------------------------------------------------
module csvfs_front (
  input  logic                   clk,
  input  logic                   rst,
  csvfs_in_if.sink               items,
  input  logic [1:0]             delim_sel,
  input  logic                   quote_sel,
  input  logic                   pop,
  output csvfs_pkg::csvfs_item_t head,
  output logic                   head_valid
);
  import csvfs_pkg::*;

  csvfs_item_t cls;
  logic        full;
  logic [7:0]  delim_c;
  logic [7:0]  quote_c;

  // classify the offered byte; an end-of-line item counts as a delimiter
  always_comb begin
    delim_c      = delim_char(delim_sel);
    quote_c      = quote_char(quote_sel);
    cls.eol      = items.op;
    cls.ch       = items.ch;
    cls.is_quote = !items.op && (items.ch == quote_c);
    cls.is_delim = items.op || (items.ch == delim_c);
    cls.is_ws    = !items.op && is_space(items.ch);
  end

  assign items.ready = !full;

  csvfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (items.valid),
    .push_item (cls),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .nonempty  (head_valid)
  );

endmodule

// ===== rtl/csvfs_back.sv =====
// ----------------------------------------------------------------------------
// csvfs_back
// Field state and result sequencer: plans each item's results, then emits
// held spaces, released quote marks and the closing result one per cycle while the result channel accepts them.
// ----------------------------------------------------------------------------
module csvfs_back #(
  parameter int MAX_PENDING_SPACES = csvfs_pkg::DEF_MAX_PENDING
) (
  input  logic                   clk,
  input  logic                   rst,
  input  csvfs_pkg::csvfs_item_t head,
  input  logic                   head_valid,
  output logic                   pop,
  input  logic                   quote_sel,
  csvfs_out_if.source            results
);
  import csvfs_pkg::*;

  localparam int PC_W     = $clog2(MAX_PENDING_SPACES + 1);
  localparam int IDX_W    = $clog2(MAX_PENDING_SPACES);
  localparam int SPAN     = MAX_PENDING_SPACES + QUOTE_RUN_MAX + 2;
  localparam int CNT_SPAN = (SPAN > OUT_LIMIT + 1) ? SPAN : OUT_LIMIT + 1;
  localparam int CNT_W    = $clog2(CNT_SPAN);

  typedef enum logic [1:0] {S_IDLE, S_SPACE, S_QUOTE, S_FINAL} state_t;
  typedef enum logic [1:0] {F_END, F_DROP, F_CHAR} fin_t;

  // field state
  logic              in_quoted;
  logic [QRUN_W-1:0] quote_run;
  logic              cell_started;
  logic              text_started;
  logic [7:0]        pend [MAX_PENDING_SPACES];
  logic [PC_W-1:0]   pending_count;
  logic              overflow_seen;

  // sequencer
  state_t            state;
  fin_t              fin;
  logic [7:0]        cur_ch;
  logic              cur_ws;
  logic              cur_eol;
  logic [QRUN_W-1:0] nq;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  res_cnt;
  logic [CNT_W-1:0]  res_lim;

  // output register
  logic       out_valid;
  logic [7:0] out_char;
  logic       out_cv;
  logic       out_fe;
  logic       out_le;
  logic       out_fd;
  logic       out_so;
  logic       out_last;

  // plan of a popped item
  logic [QRUN_W-1:0] run_adj;
  logic [QRUN_W-1:0] nq_c;
  logic [QRUN_W-1:0] rem_c;
  fin_t              fin_c;
  logic              char_out;
  logic              flush_c;
  logic              fin_emits;
  logic [CNT_W-1:0]  tot_c;
  logic [CNT_W-1:0]  lim_c;

  // per-cycle result
  logic       advance;
  logic       would_emit;
  logic       emit_en;
  logic       last_c;
  logic [7:0] r_char;
  logic       r_cv;
  logic       r_fe;
  logic       r_le;
  logic       r_fd;
  logic       r_so;

  assign pop = (state == S_IDLE) && head_valid;

  // a closing quote pair before a delimiter in a quoted field is dropped;
  // the rest of the run becomes literal quote characters, one per pair in a quoted field
  always_comb begin
    if (in_quoted && head.is_delim && !quote_run[0] && (quote_run >= QRUN_W'(2))) begin
      run_adj = quote_run - QRUN_W'(2);
    end else begin
      run_adj = quote_run;
    end
    nq_c  = in_quoted ? {1'b0, run_adj[QRUN_W-1:1]} : run_adj;
    rem_c = in_quoted ? {{(QRUN_W-1){1'b0}}, run_adj[0]} : '0;
    if (head.is_delim && (rem_c == '0)) begin
      fin_c = F_END;
    end else if (head.eol) begin
      fin_c = F_DROP;
    end else begin
      fin_c = F_CHAR;
    end
    char_out  = (fin_c == F_CHAR) && !head.is_ws;
    flush_c   = (nq_c != '0) || char_out;
    fin_emits = (fin_c != F_CHAR) || char_out;
    tot_c     = (flush_c ? CNT_W'(pending_count) : '0) + CNT_W'(nq_c)
              + CNT_W'(fin_emits);
    lim_c     = (tot_c > CNT_W'(OUT_LIMIT)) ? CNT_W'(OUT_LIMIT) : tot_c;
  end

  // result of the current sequencer step
  always_comb begin
    advance    = !out_valid || results.ready;
    would_emit = advance && ((state == S_SPACE) || (state == S_QUOTE) ||
                 ((state == S_FINAL) && ((fin != F_CHAR) || !cur_ws)));
    emit_en    = would_emit && (res_cnt < res_lim);
    last_c     = (res_cnt == res_lim - CNT_W'(1));
    r_char = '0;
    r_cv   = 1'b0;
    r_fe   = 1'b0;
    r_le   = 1'b0;
    r_fd   = 1'b0;
    r_so   = 1'b0;
    case (state)
      S_SPACE: begin
        r_char = pend[idx];
        r_cv   = 1'b1;
      end
      S_QUOTE: begin
        r_char = quote_char(quote_sel);
        r_cv   = 1'b1;
      end
      S_FINAL: begin
        case (fin)
          F_END: begin
            r_fe = 1'b1;
            r_le = cur_eol;
            r_so = overflow_seen;
          end
          F_DROP: begin
            r_fe = 1'b1;
            r_le = 1'b1;
            r_fd = 1'b1;
          end
          default: begin
            r_char = cur_ch;
            r_cv   = 1'b1;
          end
        endcase
      end
      default: ;
    endcase
  end

  // state, field state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      in_quoted     <= 1'b0;
      quote_run     <= '0;
      cell_started  <= 1'b0;
      text_started  <= 1'b0;
      pending_count <= '0;
      overflow_seen <= 1'b0;
      nq            <= '0;
      idx           <= '0;
      res_cnt       <= '0;
      res_lim       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid <= 1'b1;
        out_char  <= r_char;
        out_cv    <= r_cv;
        out_fe    <= r_fe;
        out_le    <= r_le;
        out_fd    <= r_fd;
        out_so    <= r_so;
        out_last  <= last_c;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      if (would_emit) begin
        res_cnt <= res_cnt + CNT_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (head_valid) begin
            if (head.is_quote) begin
              // quote mark: may open a quoted field, run saturates
              if ((quote_run == '0) && !cell_started) begin
                in_quoted <= 1'b1;
              end
              if (quote_run < QRUN_W'(QUOTE_RUN_MAX)) begin
                quote_run <= quote_run + QRUN_W'(1);
              end
            end else begin
              quote_run <= rem_c;
              fin       <= fin_c;
              cur_ch    <= head.ch;
              cur_ws    <= head.is_ws;
              cur_eol   <= head.eol;
              nq        <= nq_c;
              idx       <= '0;
              res_cnt   <= '0;
              res_lim   <= lim_c;
              if (flush_c && (pending_count != '0)) begin
                state <= S_SPACE;
              end else if (nq_c != '0) begin
                state <= S_QUOTE;
              end else begin
                state <= S_FINAL;
              end
            end
          end
        end

        S_SPACE: begin
          // held whitespace proven interior
          if (advance) begin
            idx <= idx + IDX_W'(1);
            if (PC_W'(idx) == pending_count - PC_W'(1)) begin
              pending_count <= '0;
              state         <= (nq != '0) ? S_QUOTE : S_FINAL;
            end
          end
        end

        S_QUOTE: begin
          // released quote marks as literal characters
          if (advance) begin
            cell_started <= 1'b1;
            text_started <= 1'b1;
            nq           <= nq - QRUN_W'(1);
            if (nq == QRUN_W'(1)) begin
              state <= S_FINAL;
            end
          end
        end

        S_FINAL: begin
          if (advance) begin
            state <= S_IDLE;
            case (fin)
              F_END, F_DROP: begin
                in_quoted     <= 1'b0;
                quote_run     <= '0;
                cell_started  <= 1'b0;
                text_started  <= 1'b0;
                pending_count <= '0;
                overflow_seen <= 1'b0;
              end
              default: begin
                cell_started <= 1'b1;
                if (!cur_ws) begin
                  text_started <= 1'b1;
                end else if (text_started) begin
                  // trailing whitespace is held until proven interior
                  if (pending_count < PC_W'(MAX_PENDING_SPACES)) begin
                    pend[pending_count[IDX_W-1:0]] <= cur_ch;
                    pending_count <= pending_count + PC_W'(1);
                  end else begin
                    overflow_seen <= 1'b1;
                  end
                end
              end
            endcase
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = out_valid;
  assign results.out_char       = out_char;
  assign results.char_valid     = out_cv;
  assign results.field_end      = out_fe;
  assign results.line_end       = out_le;
  assign results.field_dropped  = out_fd;
  assign results.space_overflow = out_so;
  assign results.last           = out_last;

  // checks on the field state and sequencer
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    quote_run <= QRUN_W'(QUOTE_RUN_MAX))
    else $error("quote run beyond its bound");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pending_count <= PC_W'(MAX_PENDING_SPACES))
    else $error("hold buffer count beyond its depth");

  a_pend_text: assert property (@(posedge clk) disable iff (rst)
    (pending_count != '0) |-> text_started)
    else $error("whitespace held before any field text");

  a_quote_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_QUOTE) |-> (nq != '0))
    else $error("quote release with nothing left to release");

  a_field_clear: assert property (@(posedge clk) disable iff (rst)
    (emit_en && (state == S_FINAL) && (fin != F_CHAR))
      |=> (!in_quoted && (pending_count == '0) && (quote_run == '0)))
    else $error("field state not cleared after field end");

endmodule

// ===== rtl/csv_field_splitter.sv =====
// An item is accepted into the two-entry queue that decouples the input, then
// popped and planned by the back end; its results are registered onto the
// result channel. A quote mark is only counted when popped; any other item
// then emits its released held spaces and quote marks and its closing result,
// if any. Reset: synchronous; clears field state, queue and output, and selects
// comma and double quote as delimiters; no clearing pass.
// ----------------------------------------------------------------------------
// csv_field_splitter
// Splits one CSV line, fed one byte per item, into trimmed field text with
// quote handling and field and line end markers.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
  parameter int MAX_PENDING_SPACES = csvfs_pkg::DEF_MAX_PENDING
) (
  input  logic        clk,
  input  logic        rst,
  csvfs_in_if.sink    items,
  csvfs_out_if.source results,
  csvfs_cfg_if.sink   cfg
);
  import csvfs_pkg::*;

  logic [1:0]  delim_sel;
  logic        quote_sel;
  csvfs_item_t head;
  logic        head_valid;
  logic        pop;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delim_sel <= '0;
      quote_sel <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FIELD_DELIM: delim_sel <= cfg.data[1:0];
        REG_QUOTE_SEL:   quote_sel <= cfg.data[0];
        default: ;
      endcase
    end
  end

  csvfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .delim_sel  (delim_sel),
    .quote_sel  (quote_sel),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  csvfs_back #(
    .MAX_PENDING_SPACES (MAX_PENDING_SPACES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .quote_sel  (quote_sel),
    .results    (results)
  );

endmodule
